@@ sv/first_fit_block_allocator_macros.svh @@
// Assertion macros for the first-fit block allocator.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define FFBA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("first_fit_block_allocator: assertion failed");
`define FFBA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  `FFBA_ASSERT(name, clk, rst_n, (ante) |-> (cons))
`else
`define FFBA_ASSERT(name, clk, rst_n, prop)
`define FFBA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/ffba_pkg.sv @@
// Shared types, codes and defaults of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  // field widths
  localparam int LEN_W  = 13;
  localparam int BIDX_W = 8;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 9;
  localparam int CFG_W  = 9;

  // parameter defaults
  localparam int MAP_BLOCKS_DEF  = 256;
  localparam int BLOCK_BYTES_DEF = 16;

  // pool size limits
  localparam int POOL_MIN   = 2;
  localparam int POOL_RESET = 256;

  localparam logic FUNC_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    BLK_FREE = 2'd0,
    BLK_OCC  = 2'd1,
    BLK_END  = 2'd2,
    BLK_RES  = 2'd3
  } blk_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NO_FIT    = 3'd2,
    STAT_RESERVED  = 3'd3,
    STAT_RANGE     = 3'd4,
    STAT_NOT_ALLOC = 3'd5
  } stat_e;

  typedef struct packed {
    logic              func;
    logic [LEN_W-1:0]  length_bytes;
    logic [BIDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BIDX_W-1:0] start_block;
    logic [CNT_W-1:0]  blocks_changed;
    logic [CNT_W-1:0]  free_blocks;
  } rsp_t;

endpackage

@@ sv/ffba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/first_fit_block_allocator.sv @@
// First-fit block allocator: block map in one RAM, walked one entry a cycle.
// Depends on ffba_pkg, ffba_ram and first_fit_block_allocator_macros.svh.
//
//  channel | signals                          | moves
//  --------+----------------------------------+---------------------------------
//  in      | in_valid_i, in_ready_o, in_req_i | one request word (ffba_pkg::req_t)
//  out     | out_valid_o, out_ready_i, out_rsp_o | one response word (rsp_t)
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | pool_blocks, always ready
//
// Allocate: a map search, then one write per block of the run, then the response is
// loaded. Free: each block of the run is read and cleared, then the response is loaded.
// Errors caught before the map is read go straight to the response. The map port has
// one read and one write per cycle. After reset and after each cfg word a clearing
// pass writes pool_blocks entries, one a cycle, with in_ready_o low. One request is in
// work at a time; the response register lets the next request enter while it waits.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator #(
  parameter int MAP_BLOCKS  = ffba_pkg::MAP_BLOCKS_DEF,
  parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ffba_pkg::req_t               in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ffba_pkg::rsp_t               out_rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ffba_pkg::CFG_W-1:0]   cfg_data_i
);

  import ffba_pkg::*;

  localparam int IW       = $clog2(MAP_BLOCKS);
  localparam int PW       = $clog2(MAP_BLOCKS + 1);
  localparam int CW       = (PW > CFG_W) ? PW : CFG_W;
  localparam int RB_W     = $clog2((1 << LEN_W) + BLOCK_BYTES);
  localparam int POOL_RST = (MAP_BLOCKS < POOL_RESET) ? MAP_BLOCKS : POOL_RESET;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SEARCH  = 6'b000100,
    S_MARK    = 6'b001000,
    S_RELEASE = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [PW-1:0]     pool_q, pool_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [PW-1:0]     addr_q, addr_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              first_q, first_d;
  logic [PW-1:0]     run_len_q, run_len_d;
  logic [PW-1:0]     run_start_q, run_start_d;
  logic [RB_W-1:0]   run_bytes_q, run_bytes_d;
  logic [LEN_W-1:0]  len_q, len_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [1:0]        ram_wdata, ram_rdata;
  blk_e              blk_rd;

  logic [CW-1:0]     cfg_ext;
  logic [PW-1:0]     pool_wr;
  logic [PW-1:0]     pool_last;
  logic              addr_in_pool;
  logic              out_free;
  logic [RB_W-1:0]   next_bytes;
  logic [PW-1:0]     next_len;
  logic [PW-1:0]     next_start;
  logic [CNT_W-1:0]  rel_free;

  ffba_ram #(
    .WIDTH(2),
    .DEPTH(MAP_BLOCKS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign blk_rd = blk_e'(ram_rdata);

  // clamp the written pool size
  assign cfg_ext = CW'(cfg_data_i);
  assign pool_wr = (cfg_ext < CW'(POOL_MIN))   ? PW'(POOL_MIN) :
                   (cfg_ext > CW'(MAP_BLOCKS)) ? PW'(MAP_BLOCKS) : PW'(cfg_ext);

  assign pool_last    = pool_q - PW'(1);
  assign addr_in_pool = (addr_q < pool_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign next_bytes   = run_bytes_q + RB_W'(BLOCK_BYTES);
  assign next_len     = run_len_q + PW'(1);
  assign next_start   = (run_len_q == '0) ? pos_q : run_start_q;
  assign rel_free     = free_q + CNT_W'(run_len_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d     = state_q;
    pool_d      = pool_q;
    free_d      = free_q;
    addr_d      = addr_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    first_d     = first_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    run_bytes_d = run_bytes_q;
    len_d       = len_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[IW-1:0];
    ram_wdata   = BLK_FREE;
    ram_re      = 1'b0;
    ram_raddr   = addr_q[IW-1:0];

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q[IW-1:0];
        ram_wdata = (addr_q == '0) ? BLK_RES : BLK_FREE;
        addr_d    = addr_q + PW'(1);
        if (addr_q == pool_last) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_d.status         = STAT_OK;
          res_d.start_block    = '0;
          res_d.blocks_changed = '0;
          res_d.free_blocks    = free_q;
          len_d       = in_req_i.length_bytes;
          addr_d      = '0;
          pend_d      = 1'b0;
          first_d     = 1'b1;
          run_len_d   = '0;
          run_bytes_d = '0;
          if (in_req_i.func == FUNC_ALLOC) begin
            if (free_q == '0) begin
              res_d.status = STAT_FULL;
              state_d      = S_DONE;
            end else if (in_req_i.length_bytes == '0) begin
              res_d.status = STAT_NO_FIT;
              state_d      = S_DONE;
            end else begin
              state_d = S_SEARCH;
            end
          end else begin
            if (in_req_i.block_index == '0) begin
              res_d.status = STAT_RESERVED;
              state_d      = S_DONE;
            end else if (CW'(in_req_i.block_index) >= CW'(pool_q)) begin
              res_d.status = STAT_RANGE;
              state_d      = S_DONE;
            end else begin
              addr_d  = PW'(in_req_i.block_index);
              state_d = S_RELEASE;
            end
          end
        end
      end

      S_SEARCH: begin
        // read ahead one entry; the entry at pos_q is judged this cycle
        ram_re = addr_in_pool;
        addr_d = addr_q + PW'(1);
        pos_d  = addr_q;
        pend_d = addr_in_pool;
        if (pend_q) begin
          if (blk_rd == BLK_FREE && next_bytes >= RB_W'(len_q)) begin
            // run complete: pos_q is its last block
            run_start_d = next_start;
            run_len_d   = next_len;
            pos_d       = pos_q;
            addr_d      = next_start;
            state_d     = S_MARK;
          end else begin
            if (blk_rd == BLK_FREE) begin
              run_start_d = next_start;
              run_len_d   = next_len;
              run_bytes_d = next_bytes;
            end else begin
              run_len_d   = '0;
              run_bytes_d = '0;
            end
            if (pos_q == pool_last) begin
              res_d.status = STAT_NO_FIT;
              state_d      = S_DONE;
            end
          end
        end
      end

      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q[IW-1:0];
        ram_wdata = (addr_q == pos_q) ? BLK_END : BLK_OCC;
        addr_d    = addr_q + PW'(1);
        if (addr_q == pos_q) begin
          free_d               = free_q - CNT_W'(run_len_q);
          res_d.status         = STAT_OK;
          res_d.start_block    = BIDX_W'(run_start_q);
          res_d.blocks_changed = CNT_W'(run_len_q);
          res_d.free_blocks    = free_q - CNT_W'(run_len_q);
          state_d              = S_DONE;
        end
      end

      S_RELEASE: begin
        ram_re = addr_in_pool;
        addr_d = addr_q + PW'(1);
        pos_d  = addr_q;
        pend_d = addr_in_pool;
        if (pend_q) begin
          first_d = 1'b0;
          if (first_q && blk_rd == BLK_FREE) begin
            res_d.status = STAT_NOT_ALLOC;
            state_d      = S_DONE;
          end else if (first_q && blk_rd == BLK_RES) begin
            res_d.status = STAT_RESERVED;
            state_d      = S_DONE;
          end else if (blk_rd inside {BLK_FREE, BLK_RES}) begin
            // run ended without an end marker
            free_d               = rel_free;
            res_d.blocks_changed = CNT_W'(run_len_q);
            res_d.free_blocks    = rel_free;
            state_d              = S_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[IW-1:0];
            ram_wdata = BLK_FREE;
            run_len_d = next_len;
            if (blk_rd == BLK_END || pos_q == pool_last) begin
              free_d               = free_q + CNT_W'(next_len);
              res_d.blocks_changed = CNT_W'(next_len);
              res_d.free_blocks    = free_q + CNT_W'(next_len);
              state_d              = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        // hold the response until the output register frees up
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a pool size write restarts the map
    if (cfg_valid_i) begin
      pool_d  = pool_wr;
      free_d  = CNT_W'(pool_wr - PW'(1));
      addr_d  = '0;
      pend_d  = 1'b0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pool_q      <= PW'(POOL_RST);
      free_q      <= CNT_W'(POOL_RST - 1);
      addr_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      free_q      <= free_d;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    first_q     <= first_d;
    run_len_q   <= run_len_d;
    run_start_q <= run_start_d;
    run_bytes_q <= run_bytes_d;
    len_q       <= len_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  `FFBA_ASSERT(a_free_below_pool, clk_i, rst_ni, CW'(free_q) < CW'(pool_q))
  `FFBA_ASSERT_IMPL(a_block0_only_cleared, clk_i, rst_ni, ram_we && ram_waddr == '0, state_q == S_CLEAR)
  `FFBA_ASSERT_IMPL(a_search_short_of_len, clk_i, rst_ni, state_q == S_SEARCH, run_bytes_q < RB_W'(len_q))
  `FFBA_ASSERT_IMPL(a_ok_moves_blocks, clk_i, rst_ni, out_valid_o && out_rsp_o.status == STAT_OK, out_rsp_o.blocks_changed != '0)

endmodule

@@ sim/first_fit_block_allocator_tb.sv @@
// Self-checking testbench for first_fit_block_allocator: directed rows, then random phases.
// Keeps its own copy of the block map to predict each response word that no row types in.
// Depends on ffba_pkg and the first_fit_block_allocator RTL.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam logic FUNC_FREE   = ~FUNC_ALLOC;
  localparam int   STALL_LIMIT = 8000;
  localparam int   HOLD_CYCLES = 400;
  localparam int   PHASE_ITEMS = 128;
  localparam int   N_PHASES    = 8;
  localparam int   RANDOM_PHASE = 6;
  localparam int   CALM_PHASE  = 3;
  localparam int   HOLD_PHASE  = 5;

  typedef struct packed {
    logic             cfg;    // 1: pool write, 0: request word
    logic [CFG_W-1:0] pool;
    req_t             req;
    logic             fixed;  // 1: rsp below is the typed-in answer
    rsp_t             rsp;
  } dir_row_t;

  typedef struct {
    bit   fixed;
    rsp_t rsp;
  } fixed_rsp_t;

  localparam rsp_t     NO_RSP = '0;
  localparam int       N_ROWS = 26;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd0},   1'b1, '{STAT_RESERVED, 8'd0, 9'd0, 9'd255}},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd5},   1'b1, '{STAT_NOT_ALLOC, 8'd0, 9'd0, 9'd255}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd0,    8'd0},   1'b1, '{STAT_NO_FIT, 8'd0, 9'd0, 9'd255}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd8191, 8'd0},   1'b1, '{STAT_NO_FIT, 8'd0, 9'd0, 9'd255}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd4096, 8'd0},   1'b1, '{STAT_NO_FIT, 8'd0, 9'd0, 9'd255}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd1,    8'd0},   1'b1, '{STAT_OK, 8'd1, 9'd1, 9'd254}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd17,   8'd0},   1'b0, NO_RSP},
    // free at the end marker, then the head that now runs into a free block
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd3},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd2},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd1},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd4080, 8'd0},   1'b1, '{STAT_OK, 8'd1, 9'd255, 9'd0}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd16,   8'd0},   1'b1, '{STAT_FULL, 8'd0, 9'd0, 9'd0}},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd128}, 1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'h0AAA, 8'd0},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd1},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'h1555, 8'd0},   1'b1, '{STAT_NO_FIT, 8'd0, 9'd0, 9'd255}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'h0AAA, 8'd0},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'hAA},  1'b0, NO_RSP},
    // pool write below the minimum acts as two blocks
    '{1'b1, 9'd0, '{FUNC_ALLOC, 13'd0,    8'd0},   1'b0, NO_RSP},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd2},   1'b1, '{STAT_RANGE, 8'd0, 9'd0, 9'd1}},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd255}, 1'b1, '{STAT_RANGE, 8'd0, 9'd0, 9'd1}},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd1},   1'b1, '{STAT_NOT_ALLOC, 8'd0, 9'd0, 9'd1}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd16,   8'd0},   1'b1, '{STAT_OK, 8'd1, 9'd1, 9'd0}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd1,    8'd0},   1'b1, '{STAT_FULL, 8'd0, 9'd0, 9'd0}},
    '{1'b0, 9'd0, '{FUNC_FREE,  13'd0,    8'd1},   1'b1, '{STAT_OK, 8'd0, 9'd1, 9'd1}},
    '{1'b0, 9'd0, '{FUNC_ALLOC, 13'd17,   8'd0},   1'b1, '{STAT_NO_FIT, 8'd0, 9'd0, 9'd1}}
  };

  localparam logic [CFG_W-1:0] PHASE_POOL [N_PHASES] = '{
    9'd511, 9'd16, 9'd1, 9'd64, 9'd257, 9'd33, 9'd0, 9'd256
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  req_t             in_req_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  rsp_t             out_rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // mirror of the block map
  blk_e        map_state [MAP_BLOCKS_DEF];
  int unsigned map_pool;
  int unsigned map_free;
  int unsigned live_runs [$];

  rsp_t       awaited_rsp_q [$];
  fixed_rsp_t fixed_rsp_q [$];
  int         fail_count   = 0;
  int         stall_cycles = 0;
  bit         tx_calm      = 1'b0;
  bit         rx_calm      = 1'b0;
  bit         rx_hold_req  = 1'b0;

  first_fit_block_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void map_reinit(input logic [CFG_W-1:0] value);
    int unsigned p;
    p = value;
    if (p < POOL_MIN) p = POOL_MIN;
    if (p > MAP_BLOCKS_DEF) p = MAP_BLOCKS_DEF;
    map_pool = p;
    foreach (map_state[k]) map_state[k] = BLK_FREE;
    map_state[0] = BLK_RES;
    map_free = p - 1;
    live_runs.delete();
  endfunction

  function automatic rsp_t map_apply_request(input req_t r);
    rsp_t        o;
    int unsigned n, s, j, b, cnt;
    bit          fit;
    blk_e        e;
    o = '0;
    o.status = STAT_OK;
    if (r.func == FUNC_ALLOC) begin
      n = (int'(r.length_bytes) + BLOCK_BYTES_DEF - 1) / BLOCK_BYTES_DEF;
      if (map_free == 0) begin
        o.status = STAT_FULL;
      end else if (n == 0 || n > map_pool) begin
        o.status = STAT_NO_FIT;
      end else begin
        o.status = STAT_NO_FIT;
        for (s = 0; s + n <= map_pool; s++) begin
          fit = 1'b1;
          for (j = 0; j < n && fit; j++) begin
            if (map_state[s + j] != BLK_FREE) fit = 1'b0;
          end
          if (fit) begin
            for (j = 0; j + 1 < n; j++) map_state[s + j] = BLK_OCC;
            map_state[s + n - 1] = BLK_END;
            map_free -= n;
            o.status = STAT_OK;
            o.start_block = s[BIDX_W-1:0];
            o.blocks_changed = n[CNT_W-1:0];
            live_runs.push_back(s);
            break;
          end
        end
      end
    end else begin
      b = r.block_index;
      if (b == 0) begin
        o.status = STAT_RESERVED;
      end else if (b >= map_pool) begin
        o.status = STAT_RANGE;
      end else if (map_state[b] == BLK_FREE) begin
        o.status = STAT_NOT_ALLOC;
      end else if (map_state[b] == BLK_RES) begin
        o.status = STAT_RESERVED;
      end else begin
        cnt = 0;
        // release through the end marker, stop early at a free or reserved block
        for (j = b; j < map_pool; j++) begin
          e = map_state[j];
          if (e == BLK_FREE || e == BLK_RES) break;
          map_state[j] = BLK_FREE;
          cnt++;
          if (e == BLK_END) break;
        end
        map_free += cnt;
        o.blocks_changed = cnt[CNT_W-1:0];
        for (int k = live_runs.size() - 1; k >= 0; k--) begin
          if (live_runs[k] >= b && live_runs[k] < b + cnt) live_runs.delete(k);
        end
      end
    end
    o.free_blocks = map_free[CNT_W-1:0];
    return o;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick, n, top;
    r.func = FUNC_ALLOC;
    r.length_bytes = 13'($urandom);
    r.block_index = 8'($urandom);
    pick = $urandom_range(99);
    top = (map_pool < 8) ? map_pool : 8;
    if (pick < 52) begin
      n = $urandom_range(1, top);
      r.length_bytes = 13'((n - 1) * BLOCK_BYTES_DEF + $urandom_range(1, BLOCK_BYTES_DEF));
    end else if (pick < 58) begin
      r.length_bytes = 13'($urandom_range(0, 4096));
    end else if (pick < 88 && live_runs.size() > 0) begin
      r.func = FUNC_FREE;
      n = live_runs[$urandom_range(0, live_runs.size() - 1)];
      // now and then aim inside a run instead of at its head
      if (pick >= 83) n += $urandom_range(1, 3);
      r.block_index = n[BIDX_W-1:0];
    end else begin
      r.func = FUNC_FREE;
    end
    return r;
  endfunction

  function automatic bit tx_gap();
    return !tx_calm && ($urandom_range(99) < 23);
  endfunction

  task automatic send_req(input req_t r, input bit fixed, input rsp_t rsp);
    fixed_rsp_t f;
    @(negedge clk_i);
    while (tx_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    f.fixed = fixed;
    f.rsp = rsp;
    fixed_rsp_q.push_back(f);
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait for every outstanding response word
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pool(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    rsp_t want;
    rsp_t model_rsp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response word: expected none, got %p", $time, out_rsp_o);
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("status", want.status, out_rsp_o.status);
          check_field("start_block", want.start_block, out_rsp_o.start_block);
          check_field("blocks_changed", want.blocks_changed, out_rsp_o.blocks_changed);
          check_field("free_blocks", want.free_blocks, out_rsp_o.free_blocks);
        end
      end
      if (cfg_valid_i && cfg_ready_o) map_reinit(cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        model_rsp = map_apply_request(in_req_i);
        want = model_rsp;
        if (fixed_rsp_q.size() > 0) begin
          if (fixed_rsp_q[0].fixed) want = fixed_rsp_q[0].rsp;
          void'(fixed_rsp_q.pop_front());
        end
        awaited_rsp_q.push_back(want);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random stalls, a calm phase, and one long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        out_ready_i <= rx_calm || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("** first_fit_block_allocator: FAILED **");
    $finish;
  end

  initial begin
    map_reinit(POOL_RESET);
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIR_ROWS[i].cfg) begin
        drain();
        write_pool(DIR_ROWS[i].pool);
      end else begin
        send_req(DIR_ROWS[i].req, DIR_ROWS[i].fixed, DIR_ROWS[i].rsp);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_pool(ph == RANDOM_PHASE ? 9'($urandom_range(3, 255)) : PHASE_POOL[ph]);
      tx_calm = (ph == CALM_PHASE);
      rx_calm = (ph == CALM_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == HOLD_PHASE && k == 40) rx_hold_req = 1'b1;
        send_req(random_request(), 1'b0, NO_RSP);
      end
    end
    drain();

    // hold on a while to catch stray response words
    repeat (600) @(posedge clk_i);
    if (fail_count == 0)
      $display("** first_fit_block_allocator: PASSED **");
    else
      $display("** first_fit_block_allocator: FAILED **");
    $finish;
  end

endmodule
